@@ hdl/lu_pkg.sv @@
// Package: shared constants and types for the LU decomposition block.
package lu_pkg;
	localparam int MAX_DIM = 8;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W = 3;
	localparam int ADDR_W = 6;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam logic [0:0] CFG_SIZE = 1'b0;
	localparam logic [0:0] CFG_STAB = 1'b1;

	typedef logic signed [31:0] word_t;

	function automatic word_t sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

@@ hdl/lu_ram.sv @@
// Generic single-port RAM with registered read.
module lu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

@@ hdl/lu_div.sv @@
// Radix-2 restoring divider for the pivot reciprocal, one quotient bit per cycle.
module lu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lu_pkg::word_t      pivot,
	output logic               done,
	output lu_pkg::word_t      recip
);
	localparam int NB = 2 * lu_pkg::FRAC_BITS + 1;
	logic [NB-1:0] num_q;
	logic [NB-1:0] quo_q;
	logic [32:0]   rem_q;
	logic [31:0]   mag_q;
	logic          neg_q;
	logic          busy_q;
	logic [5:0]    cnt_q;
	logic [33:0]   trial;

	assign trial = {rem_q, num_q[NB-1]} - {2'b00, mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NB);
				num_q <= NB'(1) << (2 * lu_pkg::FRAC_BITS);
				rem_q <= '0;
				quo_q <= '0;
				neg_q <= pivot[31];
				mag_q <= pivot[31] ? 32'(-pivot) : 32'(pivot);
			end else if (busy_q) begin
				num_q <= num_q << 1;
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[NB-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], num_q[NB-1]};
					quo_q <= {quo_q[NB-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (!neg_q)
			recip = (quo_q > NB'(32'h7fffffff)) ? 32'sh7fffffff : quo_q[31:0];
		else
			recip = (quo_q > NB'(33'h80000000)) ? 32'sh80000000 : 32'(-quo_q[31:0]);
	end
endmodule

@@ hdl/lu_decomposition_partial_pivot.sv @@
// Top level: fixed-point Crout LU decomposition with partial pivoting.
// Elements are loaded one request at a time into an 8x8 single-port matrix RAM
// (one load request per cycle while start_req is low). A request with start_req
// set stores its element and then runs the decomposition under a small
// sequencer that shares one 32x32 multiplier, one saturating subtractor and one
// bit-serial divider. Every matrix access goes through the single RAM port, so
// each multiply-accumulate step runs through S_RK2, S_RK3, S_RMUL and S_RSUB,
// each entry reduction adds S_COLI, S_RACC, S_RK1 and S_RWR, each column of a
// row swap runs through S_SWA to S_SWD and each reciprocal waits in S_DIV for
// the bit-serial divider. Then n*n results are emitted row by row; each entry
// is read in S_OUT and held in S_OUT2 until the output is not stalled. The
// block does not take a new request until the last result of a decomposition
// has been taken.
module lu_decomposition_partial_pivot (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  in_row,
	input  logic [2:0]  in_col,
	input  logic signed [31:0] elem_value,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_row,
	output logic [2:0]  out_col,
	output logic signed [31:0] lu_value,
	output logic [2:0]  perm_entry,
	output logic        odd_swaps,
	output logic        pivot_zero,
	output logic        last_result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam logic [4:0] S_IDLE = 5'd0, S_COLI = 5'd1, S_RACC = 5'd2, S_RK1 = 5'd3,
		S_RK2 = 5'd4, S_RK3 = 5'd5, S_RMUL = 5'd6, S_RSUB = 5'd7, S_RWR = 5'd8,
		S_SWA = 5'd9, S_SWB = 5'd10, S_SWC = 5'd11, S_SWD = 5'd12, S_PIV = 5'd13,
		S_PIV2 = 5'd14, S_DIV = 5'd15, S_SC1 = 5'd16, S_SC2 = 5'd17, S_SC3 = 5'd18,
		S_SC4 = 5'd19, S_OUT = 5'd20, S_OUT2 = 5'd21, S_NEXTJ = 5'd22, S_SWAP0 = 5'd23;

	logic [4:0]  state_q;
	logic [3:0]  size_q;
	lu_pkg::word_t stab_q;
	logic [2:0]  nm1_q, j_q, i_q, k_q, imax_q;
	logic [3:0]  upto_q;
	lu_pkg::word_t acc_q, a_q, best_mag_q, tmp_q, rcp_q;
	logic signed [63:0] prod_q;
	logic [2:0]  perm_q [lu_pkg::MAX_DIM];
	logic        par_q, zp_q;
	logic        outv_q;

	logic        ram_we;
	logic [5:0]  ram_addr;
	lu_pkg::word_t ram_wd, ram_rd;

	logic        div_start, div_done;
	lu_pkg::word_t div_rcp;
	logic        div_go_q;

	lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd));
	lu_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .pivot(rcp_q),
		.done(div_done), .recip(div_rcp));

	function automatic lu_pkg::word_t fx_shift(input logic signed [63:0] p);
		return lu_pkg::sat32(66'(p >>> lu_pkg::FRAC_BITS));
	endfunction

	function automatic logic [31:0] mag32(input lu_pkg::word_t v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = outv_q;
	assign odd_swaps = par_q;
	assign pivot_zero = zp_q;
	assign lu_value = ram_rd;
	assign perm_entry = perm_q[out_row];
	assign last_result = (out_row == nm1_q) && (out_col == nm1_q);

	always_comb begin
		ram_we = 1'b0;
		ram_addr = {i_q, j_q};
		ram_wd = acc_q;
		// The divider starts in the first cycle of S_DIV, once rcp_q holds the pivot.
		div_start = div_go_q;
		unique case (state_q)
			S_IDLE: begin
				ram_addr = {in_row, in_col};
				ram_wd = elem_value;
				ram_we = in_valid;
			end
			S_RK1: ram_addr = {i_q, k_q};
			S_RK2: ram_addr = {k_q, j_q};
			// Fetch a[i][k+1] so that the next product step finds it in S_RK2.
			S_RSUB: ram_addr = {i_q, k_q + 3'd1};
			S_RWR: ram_we = 1'b1;
			S_SWA: ram_addr = {j_q, k_q};
			S_SWB: ram_addr = {imax_q, k_q};
			S_SWC: begin
				// Row imax's entry is on the read port now and goes into row j.
				ram_addr = {j_q, k_q};
				ram_wd = ram_rd;
				ram_we = 1'b1;
			end
			S_SWD: begin
				ram_addr = {imax_q, k_q};
				ram_wd = tmp_q;
				ram_we = 1'b1;
			end
			S_PIV: ram_addr = {j_q, j_q};
			S_PIV2: begin
				ram_addr = {j_q, j_q};
				ram_wd = stab_q;
				ram_we = (ram_rd == 0) && (stab_q != 0);
			end
			S_SC1: ram_addr = {i_q, j_q};
			S_SC4: ram_we = 1'b1;
			S_OUT, S_OUT2: ram_addr = {out_row, out_col};
			default: ;
		endcase
		if (state_q == S_SC4) ram_wd = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q <= 4'd8;
			stab_q <= '0;
			par_q <= 1'b0;
			zp_q <= 1'b0;
			outv_q <= 1'b0;
			nm1_q <= 3'd7;
			out_row <= '0;
			out_col <= '0;
			for (int p = 0; p < lu_pkg::MAX_DIM; p++) perm_q[p] <= 3'(p);
		end else begin
			if (cfg_we) begin
				if (cfg_index == lu_pkg::CFG_SIZE) size_q <= cfg_data[3:0];
				else stab_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: if (in_valid && start_req) begin
					for (int p = 0; p < lu_pkg::MAX_DIM; p++) perm_q[p] <= 3'(p);
					par_q <= 1'b0;
					zp_q <= 1'b0;
					nm1_q <= (size_q == 0) ? 3'd0 : (size_q > 4'd8) ? 3'd7 : 3'(size_q - 4'd1);
					j_q <= '0;
					i_q <= '0;
					state_q <= S_COLI;
				end
				S_COLI: begin
					// row i of column j: reduce over k < min(i, j)
					upto_q <= (i_q < j_q) ? {1'b0, i_q} : {1'b0, j_q};
					k_q <= '0;
					if (i_q == '0) best_mag_q <= '0;
					if (i_q == j_q) imax_q <= j_q;
					state_q <= S_RACC;
				end
				S_RACC: state_q <= S_RK1;        // read a[i][j]
				S_RK1: begin
					acc_q <= ram_rd;
					state_q <= (upto_q == 0) ? S_RWR : S_RK2;
				end
				S_RK2: begin
					a_q <= ram_rd;
					state_q <= S_RK3;
				end
				S_RK3: begin
					tmp_q <= ram_rd;
					state_q <= S_RMUL;
				end
				S_RMUL: begin
					prod_q <= 64'(a_q) * 64'(tmp_q);
					state_q <= S_RSUB;
				end
				S_RSUB: begin
					acc_q <= lu_pkg::sat32(66'(acc_q) - 66'(fx_shift(prod_q)));
					k_q <= k_q + 3'd1;
					if (4'(k_q) + 4'd1 == upto_q) state_q <= S_RWR;
					else state_q <= S_RK2;
				end
				S_RWR: begin
					if (i_q >= j_q && {1'b0, mag32(acc_q)} > {1'b0, best_mag_q}) begin
						best_mag_q <= mag32(acc_q);
						imax_q <= i_q;
					end
					if (i_q == nm1_q) begin
						k_q <= '0;
						state_q <= S_SWAP0;
					end else begin
						i_q <= i_q + 3'd1;
						state_q <= S_COLI;
					end
				end
				S_SWAP0: begin
					if (imax_q != j_q) begin
						par_q <= ~par_q;
						perm_q[j_q] <= perm_q[imax_q];
						perm_q[imax_q] <= perm_q[j_q];
						state_q <= S_SWA;
					end else state_q <= S_PIV;
				end
				S_SWA: state_q <= S_SWB;
				S_SWB: begin
					tmp_q <= ram_rd;
					state_q <= S_SWC;
				end
				S_SWC: begin
					state_q <= S_SWD;
				end
				S_SWD: begin
					if (k_q == nm1_q) state_q <= S_PIV;
					else begin
						k_q <= k_q + 3'd1;
						state_q <= S_SWA;
					end
				end
				S_PIV: state_q <= S_PIV2;
				S_PIV2: begin
					if (ram_rd == 0 && stab_q == 0) begin
						zp_q <= 1'b1;
						state_q <= S_NEXTJ;
					end else begin
						rcp_q <= (ram_rd == 0) ? stab_q : ram_rd;
						state_q <= (j_q == nm1_q) ? S_NEXTJ : S_DIV;
						i_q <= j_q + 3'd1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						rcp_q <= div_rcp;
						state_q <= S_SC1;
					end
				end
				S_SC1: state_q <= S_SC2;
				S_SC2: begin
					prod_q <= 64'(ram_rd) * 64'(rcp_q);
					state_q <= S_SC3;
				end
				S_SC3: begin
					acc_q <= fx_shift(prod_q);
					state_q <= S_SC4;
				end
				S_SC4: begin
					if (i_q == nm1_q) state_q <= S_NEXTJ;
					else begin
						i_q <= i_q + 3'd1;
						state_q <= S_SC1;
					end
				end
				S_NEXTJ: begin
					if (j_q == nm1_q) begin
						out_row <= '0;
						out_col <= '0;
						state_q <= S_OUT;
					end else begin
						j_q <= j_q + 3'd1;
						i_q <= '0;
						state_q <= S_COLI;
					end
				end
				S_OUT: begin
					// RAM read of the current entry lands next cycle
					outv_q <= 1'b1;
					state_q <= S_OUT2;
				end
				S_OUT2: if (!out_stall) begin
					outv_q <= 1'b0;
					if (last_result) state_q <= S_IDLE;
					else begin
						if (out_col == nm1_q) begin
							out_col <= '0;
							out_row <= out_row + 3'd1;
						end else out_col <= out_col + 3'd1;
						state_q <= S_OUT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_go_q <= 1'b0;
		else div_go_q <= (state_q == S_PIV2) && (j_q != nm1_q) && !(ram_rd == 0 && stab_q == 0);
	end
endmodule

@@ tb/lu_decomposition_partial_pivot_tb.sv @@
// Testbench for the fixed-point LU decomposition block with partial pivoting.
`timescale 1ns / 1ps

module lu_decomposition_partial_pivot_tb;

	// One emitted entry of the combined L/U matrix, as the block reports it.
	typedef struct {
		logic [2:0]    row;
		logic [2:0]    col;
		lu_pkg::word_t value;
		logic [2:0]    perm;
		logic          odd;
		logic          zero;
		logic          last;
	} lu_entry_t;

	// The scoreboard keeps its own copy of the matrix and registers. It runs
	// the decomposition whenever a start request is accepted. The entries it
	// produces wait in a queue until the block emits them.
	class lu_scoreboard;
		logic [3:0]    size_reg;
		lu_pkg::word_t stab_reg;
		lu_pkg::word_t mat[lu_pkg::DEPTH];
		logic [2:0]    perm[lu_pkg::MAX_DIM];
		bit            parity;
		bit            zero_seen;
		lu_entry_t     lu_expected[$];
		int            errors;

		function new();
			size_reg = 4'd8;
			stab_reg = 0;
			parity = 0;
			zero_seen = 0;
			errors = 0;
			foreach (mat[i]) mat[i] = 0;
			foreach (perm[i]) perm[i] = i[2:0];
		endfunction

		function int dim();
			if (size_reg == 0) return 1;
			if (size_reg > lu_pkg::MAX_DIM) return lu_pkg::MAX_DIM;
			return int'(size_reg);
		endfunction

		function void write_reg(logic idx, logic [31:0] data);
			if (idx == lu_pkg::CFG_SIZE) begin
				size_reg = data[3:0];
			end else begin
				stab_reg = data;
			end
		endfunction

		function lu_pkg::word_t clip(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		// The arithmetic right shift floors, which is the truncation the block uses.
		function lu_pkg::word_t mul_q(lu_pkg::word_t a, lu_pkg::word_t b);
			longint p;
			p = longint'(a) * longint'(b);
			return clip(p >>> lu_pkg::FRAC_BITS);
		endfunction

		// Reciprocal truncates toward zero and saturates.
		function lu_pkg::word_t recip_q(lu_pkg::word_t d);
			longint mag;
			longint q;
			if (d == 0) return 0;
			mag = (d < 0) ? -longint'(d) : longint'(d);
			q = (longint'(1) <<< (2 * lu_pkg::FRAC_BITS)) / mag;
			if (d > 0) return (q > 64'sd2147483647) ? 32'sh7fffffff : q[31:0];
			if (q > 64'sd2147483648) return 32'sh80000000;
			return clip(-q);
		endfunction

		function lu_pkg::word_t reduced(int r, int c, int upto);
			lu_pkg::word_t acc;
			acc = mat[r * lu_pkg::MAX_DIM + c];
			for (int k = 0; k < upto; k++) begin
				acc = clip(longint'(acc) - longint'(mul_q(mat[r * lu_pkg::MAX_DIM + k],
					mat[k * lu_pkg::MAX_DIM + c])));
			end
			return acc;
		endfunction

		function void decompose(int n);
			longint best;
			longint mag;
			int imax;
			lu_pkg::word_t s;
			lu_pkg::word_t piv;
			lu_pkg::word_t rcp;
			lu_pkg::word_t t;
			logic [2:0] pt;
			foreach (perm[i]) perm[i] = i[2:0];
			parity = 0;
			zero_seen = 0;
			for (int j = 0; j < n; j++) begin
				best = 0;
				imax = j;
				for (int i = 0; i < j; i++)
					mat[i * lu_pkg::MAX_DIM + j] = reduced(i, j, i);
				for (int i = j; i < n; i++) begin
					s = reduced(i, j, j);
					mag = (s < 0) ? -longint'(s) : longint'(s);
					mat[i * lu_pkg::MAX_DIM + j] = s;
					// Strictly greater, so on a tie the first row keeps the pivot.
					if (mag > best) begin
						best = mag;
						imax = i;
					end
				end
				if (imax != j) begin
					for (int k = 0; k < n; k++) begin
						t = mat[j * lu_pkg::MAX_DIM + k];
						mat[j * lu_pkg::MAX_DIM + k] = mat[imax * lu_pkg::MAX_DIM + k];
						mat[imax * lu_pkg::MAX_DIM + k] = t;
					end
					pt = perm[j];
					perm[j] = perm[imax];
					perm[imax] = pt;
					parity = ~parity;
				end
				piv = mat[j * lu_pkg::MAX_DIM + j];
				if (piv == 0 && stab_reg != 0) begin
					piv = stab_reg;
					mat[j * lu_pkg::MAX_DIM + j] = piv;
				end
				if (piv == 0) begin
					zero_seen = 1;
				end else if (j != n - 1) begin
					rcp = recip_q(piv);
					for (int i = j + 1; i < n; i++) begin
						mat[i * lu_pkg::MAX_DIM + j] = mul_q(mat[i * lu_pkg::MAX_DIM + j], rcp);
					end
				end
			end
		endfunction

		function void note_request(logic [2:0] row, logic [2:0] col, lu_pkg::word_t val,
				logic start);
			lu_entry_t e;
			int n;
			mat[row * lu_pkg::MAX_DIM + col] = val;
			if (!start) return;
			n = dim();
			decompose(n);
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					e.row = i[2:0];
					e.col = j[2:0];
					e.value = mat[i * lu_pkg::MAX_DIM + j];
					e.perm = perm[i];
					e.odd = parity;
					e.zero = zero_seen;
					e.last = (i == n - 1 && j == n - 1);
					lu_expected.push_back(e);
				end
			end
		endfunction

		function void check_result(lu_entry_t got);
			lu_entry_t want;
			if (lu_expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result row %0d col %0d value %h",
						got.row, got.col, got.value);
				return;
			end
			want = lu_expected.pop_front();
			if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
					got.perm !== want.perm || got.odd !== want.odd ||
					got.zero !== want.zero || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected r%0d c%0d v=%h p%0d o%0d z%0d l%0d,",
						" got r%0d c%0d v=%h p%0d o%0d z%0d l%0d"},
						want.row, want.col, want.value, want.perm, want.odd, want.zero,
						want.last, got.row, got.col, got.value, got.perm, got.odd,
						got.zero, got.last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  in_row = '0;
	logic [2:0]  in_col = '0;
	logic signed [31:0] elem_value = '0;
	logic        start_req = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  out_row;
	logic [2:0]  out_col;
	logic signed [31:0] lu_value;
	logic [2:0]  perm_entry;
	logic        odd_swaps;
	logic        pivot_zero;
	logic        last_result;
	logic        cfg_we = 1'b0;
	logic        cfg_index = lu_pkg::CFG_SIZE;
	logic [31:0] cfg_data = '0;

	lu_scoreboard sb = new();
	int  send_gap_pct = 0;
	int  stall_pct = 0;
	int  requests_sent = 0;

	lu_decomposition_partial_pivot dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_row(in_row),
		.in_col(in_col),
		.elem_value(elem_value),
		.start_req(start_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_row(out_row),
		.out_col(out_col),
		.lu_value(lu_value),
		.perm_entry(perm_entry),
		.odd_swaps(odd_swaps),
		.pivot_zero(pivot_zero),
		.last_result(last_result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver decides its stall at each falling edge, so the value is
	// settled well before the rising edge that samples it.
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Every result taken at a rising edge goes to the scoreboard.
	always @(posedge clk) begin
		lu_entry_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.row = out_row;
			got.col = out_col;
			got.value = lu_value;
			got.perm = perm_entry;
			got.odd = odd_swaps;
			got.zero = pivot_zero;
			got.last = last_result;
			sb.check_result(got);
		end
	end

	// Drives one request and holds it until the block takes it. Valid is left
	// high on return; the next call either keeps it high or opens a gap, so it
	// is never dropped and raised within one time step.
	task automatic send_req(logic [2:0] row, logic [2:0] col, lu_pkg::word_t val,
			logic start);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_row = row;
		in_col = col;
		elem_value = val;
		start_req = start;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(row, col, val, start);
		requests_sent++;
		@(negedge clk);
	endtask

	// Lets the block drain completely. The extra cycles cover the case where
	// it is still busy after the last expected entry has been taken.
	task automatic drain();
		in_valid = 1'b0;
		start_req = 1'b0;
		while (sb.lu_expected.size() != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Phase 0 has no idling at all; the others stress each side and then both.
	task automatic set_phase(int ph);
		case (ph % 4)
			0: begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_gap_pct = 87;
				stall_pct = 0;
			end
			2: begin
				send_gap_pct = 0;
				stall_pct = 87;
			end
			default: begin
				send_gap_pct = 19;
				stall_pct = 19;
			end
		endcase
	endtask

	// Element flavors: small fractions, full range, mostly zero (which makes zero
	// pivots likely), small integers (which make ties likely) and extreme values.
	function automatic lu_pkg::word_t pick_elem(int flavor);
		case (flavor)
			0: return lu_pkg::word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			1: return lu_pkg::word_t'($urandom);
			2: return ($urandom_range(3) == 0) ?
				lu_pkg::word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000 : 0;
			3: return (lu_pkg::word_t'($urandom_range(0, 4)) - 2) <<< lu_pkg::FRAC_BITS;
			default: begin
				case ($urandom_range(4))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					2: return -1;
					3: return 1;
					default: return 0;
				endcase
			end
		endcase
	endfunction

	// Loads every cell of the active n-by-n matrix in shuffled order, after a
	// few stray writes anywhere, and starts on the final cell.
	task automatic load_matrix(int n, int flavor, int noise);
		int order[lu_pkg::DEPTH];
		int cnt;
		int k;
		int tmp;
		cnt = 0;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				order[cnt] = r * lu_pkg::MAX_DIM + c;
				cnt++;
			end
		for (int i = cnt - 1; i > 0; i--) begin
			k = $urandom_range(i);
			tmp = order[i];
			order[i] = order[k];
			order[k] = tmp;
		end
		repeat (noise)
			send_req(3'($urandom_range(7)), 3'($urandom_range(7)),
				lu_pkg::word_t'($urandom), 1'b0);
		for (int i = 0; i < cnt; i++)
			send_req(3'(order[i] / lu_pkg::MAX_DIM), 3'(order[i] % lu_pkg::MAX_DIM),
				pick_elem(flavor), i == cnt - 1);
	endtask

	// Safety net against a hung block.
	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		int pick;
		int n;
		logic [3:0] size_raw;
		lu_pkg::word_t stab;
		int round;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part on a 2x2 matrix. A zero first column gives a zero pivot
		// with the stabilizer off.
		write_reg(lu_pkg::CFG_SIZE, 32'd2);
		write_reg(lu_pkg::CFG_STAB, 32'd0);
		send_req(3'd0, 3'd0, 0, 1'b0);
		send_req(3'd1, 3'd0, 0, 1'b0);
		send_req(3'd0, 3'd1, 32'sh10000, 1'b0);
		send_req(3'd1, 3'd1, 32'sh20000, 1'b1);
		// Equal magnitudes in the first column: the upper row keeps the pivot.
		send_req(3'd0, 3'd0, -32'sh30000, 1'b0);
		send_req(3'd1, 3'd0, 32'sh30000, 1'b1);
		// The lower entry is now slightly smaller in magnitude, so the rows stay in place.
		send_req(3'd0, 3'd0, 32'sh10000, 1'b1);
		// Repeated start decomposes the previous result in place.
		send_req(3'd7, 3'd7, lu_pkg::word_t'($urandom), 1'b1);
		// Extremes of the element range.
		send_req(3'd0, 3'd0, 32'sh80000000, 1'b0);
		send_req(3'd0, 3'd1, 32'sh7fffffff, 1'b0);
		send_req(3'd1, 3'd0, 32'sh7fffffff, 1'b0);
		send_req(3'd1, 3'd1, 32'sh80000000, 1'b1);
		drain();
		// A zero matrix with the stabilizer on.
		write_reg(lu_pkg::CFG_STAB, 32'h00008000);
		send_req(3'd0, 3'd0, 0, 1'b0);
		send_req(3'd0, 3'd1, 0, 1'b0);
		send_req(3'd1, 3'd0, 0, 1'b0);
		send_req(3'd1, 3'd1, 0, 1'b1);
		drain();
		// Size zero is treated as a 1x1 matrix.
		write_reg(lu_pkg::CFG_SIZE, 32'd0);
		send_req(3'd0, 3'd0, 0, 1'b1);
		drain();
		write_reg(lu_pkg::CFG_STAB, 32'h80000000);
		send_req(3'd0, 3'd0, 0, 1'b1);
		drain();
		write_reg(lu_pkg::CFG_STAB, 32'd0);
		send_req(3'd0, 3'd0, 32'sh50000, 1'b1);
		drain();

		// Random part: one matrix per round, with fresh settings and a new
		// idling phase each time. Most sizes are small to keep the run short.
		round = 0;
		while (requests_sent < 400) begin
			set_phase(round);
			pick = $urandom_range(99);
			if (pick < 45) size_raw = 4'($urandom_range(1, 3));
			else if (pick < 75) size_raw = 4'($urandom_range(4, 6));
			else if (pick < 88) size_raw = 4'd8;
			else if (pick < 94) size_raw = 4'd7;
			else if (pick < 97) size_raw = 4'd0;
			else size_raw = 4'($urandom_range(9, 15));
			case ($urandom_range(5))
				0, 1, 2: stab = 0;
				3: stab = lu_pkg::word_t'($urandom);
				4: stab = pick_elem(4);
				default: stab = pick_elem(0);
			endcase
			write_reg(lu_pkg::CFG_SIZE, {28'd0, size_raw});
			write_reg(lu_pkg::CFG_STAB, stab);
			n = sb.dim();
			load_matrix(n, $urandom_range(4), $urandom_range(4));
			if ($urandom_range(3) == 0)
				send_req(3'($urandom_range(7)), 3'($urandom_range(7)),
					lu_pkg::word_t'($urandom), 1'b1);
			drain();
			round++;
		end

		set_phase(0);
		drain();
		if (sb.errors == 0 && sb.lu_expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
